// File: design/gdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_pkg
// Shared types and constants for the graph traversal block.
// ----------------------------------------------------------------------------
package gdt_pkg;

   localparam int VERTICES = 1024;
   localparam int EDGES    = 4096;
   localparam int VW       = $clog2(VERTICES);
   localparam int EW       = $clog2(EDGES);
   localparam int PW       = EW + 1;
   localparam int HW       = VW + 1;
   localparam int EPW      = 8;
   localparam logic [PW-1:0] NIL = PW'(EDGES);

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_DFS  = 2'd1;
   localparam logic [1:0] MODE_BFS  = 2'd2;
   localparam logic [1:0] MODE_NEXT = 2'd3;

   localparam logic [1:0] STAT_VISIT  = 2'd0;
   localparam logic [1:0] STAT_FINISH = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  edge_source;
      logic [9:0]  edge_target;
      logic [9:0]  start_vertex;
   } req_word_type;

   typedef struct packed {
      logic [9:0] vertex;
      logic [1:0] status;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } res_type;

   typedef struct packed {
      logic [VW-1:0] target;
      logic [PW-1:0] link;
   } pool_entry_type;

   typedef enum logic [1:0] {
      K_IDLE, K_DFS, K_BFS, K_ARMED
   } kind_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE,
      S_L_HEAD, S_L_CHK, S_L_POOL, S_L_INS, S_L_LINK,
      S_MARK,
      S_A_Q, S_A_LH, S_A_ST,
      S_D_TOP, S_D_CUR, S_D_POOL, S_D_VIS, S_D_LH,
      S_B_Q, S_B_LH, S_B_CUR, S_B_CHK, S_B_POOL, S_B_VIS,
      S_EMIT
   } state_type;

endpackage

// File: design/gdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_ram
// Simple dual-port memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/gdt_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdt_walk
// Sequencer over the adjacency, visited, stack and queue memories.
// ----------------------------------------------------------------------------
module gdt_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  gdt_pkg::req_word_type in_word,
   output logic                  in_ready,
   output gdt_pkg::res_type      res,
   input  logic                  res_ready
);
   import gdt_pkg::*;

   state_type       state_ff, state_in;
   kind_type        kind_ff, kind_in;
   logic [EPW-1:0]  epoch_ff, epoch_in;
   logic [PW-1:0]   used_ff, used_in;
   logic [HW-1:0]   head_ff, head_in;
   logic [HW-1:0]   tail_ff, tail_in;
   logic [VW-1:0]   cnt_ff, cnt_in;
   logic            clr_all_ff, clr_all_in;
   logic            bfs_ff, bfs_in;
   logic [VW-1:0]   vert_ff, vert_in;
   logic [VW-1:0]   tgt_ff, tgt_in;
   logic [PW-1:0]   cur_ff, cur_in;
   logic [PW-1:0]   prev_ff, prev_in;
   logic [VW-1:0]   prev_tgt_ff, prev_tgt_in;
   rsp_word_type    word_ff, word_in;

   logic            lh_we;
   logic [VW-1:0]   lh_wa, lh_ra;
   logic [PW-1:0]   lh_wd, lh_rd;
   logic            pl_we;
   logic [EW-1:0]   pl_wa, pl_ra;
   pool_entry_type  pl_wd, pl_rd;
   logic            vs_we;
   logic [VW-1:0]   vs_wa, vs_ra;
   logic [EPW-1:0]  vs_wd, vs_rd;
   logic            sk_we;
   logic [VW-1:0]   sk_wa, sk_ra;
   logic [PW-1:0]   sk_wd, sk_rd;
   logic            qu_we;
   logic [VW-1:0]   qu_wa, qu_ra;
   logic [VW-1:0]   qu_wd, qu_rd;

   logic            accept;
   logic [HW-1:0]   top_idx;

   assign accept  = in_valid && (state_ff == S_IDLE);
   assign top_idx = head_ff - HW'(1);

   gdt_ram #(.WIDTH(PW), .DEPTH(VERTICES)) u_head (
      .clock(clock), .we(lh_we), .waddr(lh_wa), .wdata(lh_wd), .raddr(lh_ra), .rdata(lh_rd));
   gdt_ram #(.WIDTH(VW + PW), .DEPTH(EDGES)) u_pool (
      .clock(clock), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
   gdt_ram #(.WIDTH(EPW), .DEPTH(VERTICES)) u_vis (
      .clock(clock), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));
   gdt_ram #(.WIDTH(PW), .DEPTH(VERTICES)) u_stack (
      .clock(clock), .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
   gdt_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_queue (
      .clock(clock), .we(qu_we), .waddr(qu_wa), .wdata(qu_wd), .raddr(qu_ra), .rdata(qu_rd));

   // next state and datapath registers
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      epoch_in    = epoch_ff;
      used_in     = used_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      clr_all_in  = clr_all_ff;
      bfs_in      = bfs_ff;
      vert_in     = vert_ff;
      tgt_in      = tgt_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      prev_tgt_in = prev_tgt_ff;
      word_in     = word_ff;
      unique case (state_ff)
         S_CLR: begin
            cnt_in = cnt_ff + VW'(1);
            if (cnt_ff == VW'(VERTICES - 1)) begin
               epoch_in = EPW'(1);
               state_in = clr_all_ff ? S_IDLE : S_MARK;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (in_word.mode)
                  MODE_LOAD: begin
                     vert_in = in_word.edge_source;
                     tgt_in  = in_word.edge_target;
                     if (used_ff == NIL) begin
                        word_in  = '{vertex: '0, status: STAT_REJECT};
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_L_HEAD;
                     end
                  end
                  MODE_DFS, MODE_BFS: begin
                     vert_in = in_word.start_vertex;
                     bfs_in  = (in_word.mode == MODE_BFS);
                     if (epoch_ff == '1) begin
                        cnt_in     = '0;
                        clr_all_in = 1'b0;
                        state_in   = S_CLR;
                     end else begin
                        epoch_in = epoch_ff + EPW'(1);
                        state_in = S_MARK;
                     end
                  end
                  MODE_NEXT: begin
                     unique case (kind_ff)
                        K_IDLE: begin
                           word_in  = '{vertex: '0, status: STAT_FINISH};
                           state_in = S_EMIT;
                        end
                        K_ARMED: state_in = S_A_Q;
                        K_DFS:   state_in = S_D_TOP;
                        K_BFS:   state_in = S_B_Q;
                        default: state_in = S_IDLE;
                     endcase
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_L_HEAD: begin
            cur_in   = lh_rd;
            prev_in  = NIL;
            state_in = S_L_CHK;
         end
         S_L_CHK: begin
            state_in = (cur_ff == NIL) ? S_L_INS : S_L_POOL;
         end
         S_L_POOL: begin
            if (pl_rd.target < tgt_ff) begin
               prev_in     = cur_ff;
               prev_tgt_in = pl_rd.target;
               cur_in      = pl_rd.link;
               state_in    = S_L_CHK;
            end else begin
               state_in = S_L_INS;
            end
         end
         S_L_INS: state_in = S_L_LINK;
         S_L_LINK: begin
            used_in  = used_ff + PW'(1);
            state_in = S_IDLE;
         end
         S_MARK: begin
            head_in  = '0;
            tail_in  = bfs_ff ? HW'(1) : HW'(0);
            kind_in  = bfs_ff ? K_BFS : K_ARMED;
            state_in = S_IDLE;
         end
         S_A_Q: state_in = S_A_LH;
         S_A_LH: begin
            vert_in  = qu_rd;
            state_in = S_A_ST;
         end
         S_A_ST: begin
            head_in  = HW'(1);
            kind_in  = K_DFS;
            word_in  = '{vertex: vert_ff, status: STAT_VISIT};
            state_in = S_EMIT;
         end
         S_D_TOP: begin
            if (head_ff == '0) begin
               word_in  = '{vertex: '0, status: STAT_FINISH};
               state_in = S_EMIT;
            end else begin
               state_in = S_D_CUR;
            end
         end
         S_D_CUR: begin
            if (sk_rd == NIL) begin
               head_in  = top_idx;
               state_in = S_D_TOP;
            end else begin
               state_in = S_D_POOL;
            end
         end
         S_D_POOL: begin
            vert_in  = pl_rd.target;
            state_in = S_D_VIS;
         end
         S_D_VIS: begin
            if (vs_rd == epoch_ff) begin
               state_in = S_D_TOP;
            end else if (head_ff < HW'(VERTICES)) begin
               state_in = S_D_LH;
            end else begin
               word_in  = '{vertex: vert_ff, status: STAT_VISIT};
               state_in = S_EMIT;
            end
         end
         S_D_LH: begin
            head_in  = head_ff + HW'(1);
            word_in  = '{vertex: vert_ff, status: STAT_VISIT};
            state_in = S_EMIT;
         end
         S_B_Q: begin
            if (head_ff >= tail_ff) begin
               word_in  = '{vertex: '0, status: STAT_FINISH};
               state_in = S_EMIT;
            end else begin
               head_in  = head_ff + HW'(1);
               state_in = S_B_LH;
            end
         end
         S_B_LH: begin
            vert_in  = qu_rd;
            state_in = S_B_CUR;
         end
         S_B_CUR: begin
            cur_in   = lh_rd;
            state_in = S_B_CHK;
         end
         S_B_CHK: begin
            if (cur_ff == NIL) begin
               word_in  = '{vertex: vert_ff, status: STAT_VISIT};
               state_in = S_EMIT;
            end else begin
               state_in = S_B_POOL;
            end
         end
         S_B_POOL: begin
            tgt_in   = pl_rd.target;
            cur_in   = pl_rd.link;
            state_in = S_B_VIS;
         end
         S_B_VIS: begin
            if (vs_rd != epoch_ff && tail_ff < HW'(VERTICES)) begin
               tail_in = tail_ff + HW'(1);
            end
            state_in = S_B_CHK;
         end
         S_EMIT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory ports and handshake outputs
   always_comb begin
      in_ready   = (state_ff == S_IDLE);
      res.valid  = (state_ff == S_EMIT);
      res.word   = word_ff;
      lh_we = 1'b0; lh_wa = vert_ff;  lh_wd = NIL; lh_ra = vert_ff;
      pl_we = 1'b0; pl_wa = used_ff[EW-1:0];
      pl_wd = '{target: tgt_ff, link: cur_ff};
      pl_ra = cur_ff[EW-1:0];
      vs_we = 1'b0; vs_wa = vert_ff;  vs_wd = epoch_ff; vs_ra = vert_ff;
      sk_we = 1'b0; sk_wa = top_idx[VW-1:0]; sk_wd = NIL; sk_ra = top_idx[VW-1:0];
      qu_we = 1'b0; qu_wa = tail_ff[VW-1:0]; qu_wd = tgt_ff; qu_ra = head_ff[VW-1:0];
      unique case (state_ff)
         S_CLR: begin
            vs_we = 1'b1;
            vs_wa = cnt_ff;
            vs_wd = '0;
            lh_we = clr_all_ff;
            lh_wa = cnt_ff;
            lh_wd = NIL;
         end
         S_IDLE: begin
            lh_ra = in_word.edge_source;
         end
         S_L_CHK: begin
            pl_ra = cur_ff[EW-1:0];
         end
         S_L_INS: begin
            pl_we = 1'b1;
            pl_wa = used_ff[EW-1:0];
            pl_wd = '{target: tgt_ff, link: cur_ff};
         end
         S_L_LINK: begin
            if (prev_ff == NIL) begin
               lh_we = 1'b1;
               lh_wa = vert_ff;
               lh_wd = used_ff;
            end else begin
               pl_we = 1'b1;
               pl_wa = prev_ff[EW-1:0];
               pl_wd = '{target: prev_tgt_ff, link: used_ff};
            end
         end
         S_MARK: begin
            vs_we = 1'b1;
            vs_wa = vert_ff;
            vs_wd = epoch_ff;
            qu_we = 1'b1;
            qu_wa = '0;
            qu_wd = vert_ff;
         end
         S_A_Q: begin
            qu_ra = '0;
         end
         S_A_LH: begin
            lh_ra = qu_rd;
         end
         S_A_ST: begin
            sk_we = 1'b1;
            sk_wa = '0;
            sk_wd = lh_rd;
         end
         S_D_TOP: begin
            sk_ra = top_idx[VW-1:0];
         end
         S_D_CUR: begin
            pl_ra = sk_rd[EW-1:0];
         end
         S_D_POOL: begin
            sk_we = 1'b1;
            sk_wa = top_idx[VW-1:0];
            sk_wd = pl_rd.link;
            vs_ra = pl_rd.target;
         end
         S_D_VIS: begin
            vs_we = (vs_rd != epoch_ff);
            vs_wa = vert_ff;
            vs_wd = epoch_ff;
            lh_ra = vert_ff;
         end
         S_D_LH: begin
            sk_we = 1'b1;
            sk_wa = head_ff[VW-1:0];
            sk_wd = lh_rd;
         end
         S_B_Q: begin
            qu_ra = head_ff[VW-1:0];
         end
         S_B_LH: begin
            lh_ra = qu_rd;
         end
         S_B_CHK: begin
            pl_ra = cur_ff[EW-1:0];
         end
         S_B_POOL: begin
            vs_ra = pl_rd.target;
         end
         S_B_VIS: begin
            vs_we = (vs_rd != epoch_ff);
            vs_wa = tgt_ff;
            vs_wd = epoch_ff;
            qu_we = (vs_rd != epoch_ff) && (tail_ff < HW'(VERTICES));
            qu_wa = tail_ff[VW-1:0];
            qu_wd = tgt_ff;
         end
         default: begin
            in_ready = (state_ff == S_IDLE);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         kind_ff    <= K_IDLE;
         epoch_ff   <= '0;
         used_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         cnt_ff     <= '0;
         clr_all_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         epoch_ff   <= epoch_in;
         used_ff    <= used_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         cnt_ff     <= cnt_in;
         clr_all_ff <= clr_all_in;
      end
      bfs_ff      <= bfs_in;
      vert_ff     <= vert_in;
      tgt_ff      <= tgt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      prev_tgt_ff <= prev_tgt_in;
      word_ff     <= word_in;
   end

endmodule

// File: design/graph_dfs_bfs_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal
// Directed graph store with depth-first and breadth-first walks.
// ----------------------------------------------------------------------------
// load: walks the source list in target order, inserts the edge, links it in
// start: marks the start vertex, plus a visited sweep once every 255 starts
// next: depth-first pops emptied levels until an unvisited neighbor is found,
// breadth-first dequeues a vertex and queues its unvisited neighbors
// one word in work at a time; result held in an output register
// reset: sweep of list heads and visited map, req_stall high
module graph_dfs_bfs_traversal (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gdt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gdt_pkg::rsp_word_type rsp_word
);
   import gdt_pkg::*;

   logic         in_ready;
   res_type      res;
   logic         load;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   gdt_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_word  (req_word),
      .in_ready (in_ready),
      .res      (res),
      .res_ready(load)
   );

   assign load         = res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_word_ff <= res.word;
      end
   end

   assign req_stall = !in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: verif/graph_dfs_bfs_traversal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_bfs_traversal_checker
// Watches both channels of the graph traversal block. Each accepted request
// word updates a private copy of the graph store and walk state, and any
// response it causes is queued. Each accepted response word is compared,
// field by field, with the oldest queued response.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_traversal_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  gdt_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  gdt_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    pending_count,
   output int                    visit_count,
   output int                    finish_count,
   output int                    reject_count
);
   import gdt_pkg::*;

   int unsigned      list_first[VERTICES];
   int unsigned      edge_target[EDGES];
   int unsigned      edge_next[EDGES];
   int unsigned      edges_used;
   bit               marked[VERTICES];
   int unsigned      cursor_at[VERTICES];
   int unsigned      visit_fifo[VERTICES];
   int unsigned      walk_head;
   int unsigned      walk_tail;
   kind_type         walk;
   rsp_word_type     expected_words[$];
   int               fails;

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
      fails++;
   endtask

   function automatic void clear_graph();
      for (int i = 0; i < VERTICES; i++) begin
         list_first[i] = EDGES;
         marked[i] = 0;
      end
      edges_used = 0;
      walk_head = 0;
      walk_tail = 0;
      walk = K_IDLE;
   endfunction

   function automatic void traverse_step(input req_word_type w, output bit got,
                                         output rsp_word_type r);
      int unsigned src, tgt, prev, cur, v, c;
      bit          done;
      got = 0;
      r = '0;
      case (w.mode)
         MODE_LOAD: begin
            src = w.edge_source;
            tgt = w.edge_target;
            if (edges_used >= EDGES) begin
               got = 1;
               r.status = STAT_REJECT;
            end else begin
               prev = EDGES;
               cur = list_first[src];
               while (cur < EDGES && edge_target[cur] < tgt) begin
                  prev = cur;
                  cur = edge_next[cur];
               end
               edge_target[edges_used] = tgt;
               edge_next[edges_used] = cur;
               if (prev == EDGES) list_first[src] = edges_used;
               else edge_next[prev] = edges_used;
               edges_used++;
            end
         end
         MODE_DFS, MODE_BFS: begin
            for (int i = 0; i < VERTICES; i++) marked[i] = 0;
            walk_head = 0;
            walk_tail = 0;
            v = w.start_vertex;
            marked[v] = 1;
            visit_fifo[0] = v;
            if (w.mode == MODE_BFS) begin
               walk_tail = 1;
               walk = K_BFS;
            end else begin
               walk = K_ARMED;
            end
         end
         default: begin
            got = 1;
            r.status = STAT_FINISH;
            case (walk)
               K_ARMED: begin
                  v = visit_fifo[0];
                  walk = K_DFS;
                  cursor_at[0] = list_first[v];
                  walk_head = 1;
                  r.vertex = v[9:0];
                  r.status = STAT_VISIT;
               end
               K_DFS: begin
                  done = 0;
                  while (!done && walk_head > 0) begin
                     c = cursor_at[walk_head-1];
                     if (c >= EDGES) begin
                        walk_head--;
                     end else begin
                        tgt = edge_target[c];
                        cursor_at[walk_head-1] = edge_next[c];
                        if (!marked[tgt]) begin
                           marked[tgt] = 1;
                           if (walk_head < VERTICES) begin
                              cursor_at[walk_head] = list_first[tgt];
                              walk_head++;
                           end
                           r.vertex = tgt[9:0];
                           r.status = STAT_VISIT;
                           done = 1;
                        end
                     end
                  end
                  if (!done) walk_head = 0;
               end
               K_BFS: begin
                  if (walk_head < walk_tail && walk_head < VERTICES) begin
                     v = visit_fifo[walk_head];
                     walk_head++;
                     c = list_first[v];
                     while (c < EDGES) begin
                        tgt = edge_target[c];
                        if (!marked[tgt]) begin
                           marked[tgt] = 1;
                           if (walk_tail < VERTICES) begin
                              visit_fifo[walk_tail] = tgt;
                              walk_tail++;
                           end
                        end
                        c = edge_next[c];
                     end
                     r.vertex = v[9:0];
                     r.status = STAT_VISIT;
                  end
               end
               default: ;
            endcase
         end
      endcase
   endfunction

   always @(posedge clock) begin
      bit           got;
      rsp_word_type r, e;
      if (reset) begin
         clear_graph();
         expected_words.delete();
         fails = 0;
         visit_count <= 0;
         finish_count <= 0;
         reject_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report("unexpected word, status", rsp_word.status, -1);
            end else begin
               e = expected_words.pop_front();
               if (rsp_word.status !== e.status)
                  report("status", rsp_word.status, e.status);
               if (rsp_word.vertex !== e.vertex)
                  report("vertex", rsp_word.vertex, e.vertex);
               case (e.status)
                  STAT_VISIT:  visit_count <= visit_count + 1;
                  STAT_FINISH: finish_count <= finish_count + 1;
                  default:     reject_count <= reject_count + 1;
               endcase
            end
         end
         if (req_valid && !req_stall) begin
            traverse_step(req_word, got, r);
            if (got) expected_words.push_back(r);
         end
      end
      fail_count <= fails;
      pending_count <= expected_words.size();
   end

endmodule

// File: verif/tb_graph_dfs_bfs_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_dfs_bfs_traversal
// Drives edge loads and depth-first and breadth-first walks into the graph
// traversal block with bursty requests and patterned response stalls, then
// spreads edges over the full vertex range and walks the larger graph; the
// checker scores every response word.
// ----------------------------------------------------------------------------
module tb_graph_dfs_bfs_traversal;
   import gdt_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   int           fail_count, pending_count, visit_count, finish_count, reject_count;
   int           burst_left;
   int           stall_phase;
   int           idle_cycles;
   int           words_sent;

   graph_dfs_bfs_traversal i_dut (.*);
   graph_dfs_bfs_traversal_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase / 300) % 4)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(3) == 0);
            2: rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= (stall_phase % 23) < 9;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send(input logic [1:0] mode, input int src, input int tgt,
                       input int start);
      req_word_type w;
      w.mode = mode;
      w.edge_source = src[9:0];
      w.edge_target = tgt[9:0];
      w.start_vertex = start[9:0];
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_random_noise();
      send(2'($urandom_range(3)), $urandom_range(1023), $urandom_range(1023),
           $urandom_range(1023));
   endtask

   // loads into vertices 0 to span, a start, then next words with occasional loads
   task automatic walk_episode(input int span);
      for (int i = $urandom_range(0, 8); i > 0; i--)
         send(MODE_LOAD, $urandom_range(span), $urandom_range(span), $urandom);
      send($urandom_range(1) ? MODE_DFS : MODE_BFS, $urandom, $urandom,
           $urandom_range(span));
      for (int i = $urandom_range(1, 50); i > 0; i--) begin
         if ($urandom_range(9) == 0)
            send(MODE_LOAD, $urandom_range(span), $urandom_range(span), $urandom);
         else
            send(MODE_NEXT, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_word = '0;
      burst_left = 0;
      words_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      send(MODE_NEXT, 0, 0, 0);
      send(MODE_LOAD, 5, 9, 0);
      send(MODE_LOAD, 5, 2, 0);
      send(MODE_LOAD, 5, 9, 0);
      send(MODE_LOAD, 5, 7, 0);
      send(MODE_LOAD, 2, 5, 0);
      send(MODE_LOAD, 9, 0, 0);
      send(MODE_LOAD, 0, 1023, 0);
      send(MODE_LOAD, 1023, 5, 1023);
      send(MODE_DFS, 1023, 1023, 5);
      repeat (7) send(MODE_NEXT, 1023, 1023, 1023);
      send(MODE_BFS, 0, 0, 5);
      repeat (3) send(MODE_NEXT, 0, 0, 0);
      send(MODE_LOAD, 2, 1, 0);
      send(MODE_DFS, 0, 0, 1023);
      repeat (3) send(MODE_NEXT, 0, 0, 0);

      while (words_sent < 1250) begin
         if ($urandom_range(7) == 0) send_random_noise();
         else walk_episode($urandom_range(1) ? 15 : 63);
      end

      // spread edges over the full vertex range, then walk the larger graph
      for (int i = 0; i < 100; i++)
         send(MODE_LOAD, $urandom_range(1023), $urandom_range(1023), $urandom);
      repeat (2) walk_episode(1023);

      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d request words: %0d visits, %0d finishes, %0d rejected edges",
               words_sent, visit_count, finish_count, reject_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
design/gdt_pkg.sv
design/gdt_ram.sv
design/gdt_walk.sv
design/graph_dfs_bfs_traversal.sv
verif/graph_dfs_bfs_traversal_checker.sv
verif/tb_graph_dfs_bfs_traversal.sv
